/* hdl/cif_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_pkg: shared definitions of the 3x3 image filter
// Widths, register indexes and the structures passed between the stages.
// ----------------------------------------------------------------------------
package cif_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 7;
   localparam int PIXEL_W    = 8;
   localparam int TAP_W      = 16;
   localparam int PROD_W     = 24;
   localparam int VALUE_W    = 28;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int RESULT_N   = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_MID    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_BORDER_MODE   = 3'd5;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic [2:0][2:0][TAP_W-1:0] taps;
      logic [SIZE_W-1:0]          width;
      logic [SIZE_W-1:0]          height;
      logic                       padded;
   } cfg_type;

   typedef struct packed {
      pixel_type [2:0][2:0] window;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
   } job_type;

endpackage

/* hdl/cif_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_req_if: pixel input channel
// Valid/ready channel carrying one pixel and its frame start flag.
// ----------------------------------------------------------------------------
interface cif_req_if;
   logic                         valid;
   logic                         ready;
   logic [cif_pkg::PIXEL_W-1:0]  pixel;
   logic                         frame_start;

   modport source (output valid, pixel, frame_start, input ready);
   modport sink   (input valid, pixel, frame_start, output ready);
endinterface

/* hdl/cif_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_rsp_if: result output channel
// Valid/ready channel carrying one filter result and its position.
// ----------------------------------------------------------------------------
interface cif_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cif_pkg::VALUE_W-1:0]  value;
   logic [cif_pkg::ROW_W-1:0]           out_row;
   logic [cif_pkg::COL_W-1:0]           out_col;
   logic                                last;
   logic                                frame_end;

   modport source (output valid, value, out_row, out_col, last, frame_end, input ready);
   modport sink   (input valid, value, out_row, out_col, last, frame_end, output ready);
endinterface

/* hdl/cif_csr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cif_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cif_pkg::CSR_ADDR_W-1:0]  index;
   logic [cif_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/cif_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/cif_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_csr: configuration registers
// Holds the taps, image size and border mode; sizes are clamped on the way out.
// ----------------------------------------------------------------------------
module cif_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cif_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [cif_pkg::CSR_DATA_W-1:0]   csr_data,
   output cif_pkg::cfg_type                 cfg
);

   localparam int TW = cif_pkg::TAP_W;
   localparam int SW = cif_pkg::SIZE_W;

   logic [3*TW-1:0] row_top_ff, row_top_in;
   logic [3*TW-1:0] row_mid_ff, row_mid_in;
   logic [3*TW-1:0] row_bot_ff, row_bot_in;
   logic [SW-1:0]   width_ff, width_in;
   logic [SW-1:0]   height_ff, height_in;
   logic            mode_ff, mode_in;

   assign csr_ready = 1'b1;

   always_comb begin
      row_top_in = row_top_ff;
      row_mid_in = row_mid_ff;
      row_bot_in = row_bot_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      mode_in    = mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cif_pkg::CSR_KERNEL_TOP:    row_top_in = csr_data[3*TW-1:0];
            cif_pkg::CSR_KERNEL_MID:    row_mid_in = csr_data[3*TW-1:0];
            cif_pkg::CSR_KERNEL_BOTTOM: row_bot_in = csr_data[3*TW-1:0];
            cif_pkg::CSR_IMAGE_WIDTH:   width_in   = csr_data[SW-1:0];
            cif_pkg::CSR_IMAGE_HEIGHT:  height_in  = csr_data[SW-1:0];
            cif_pkg::CSR_BORDER_MODE:   mode_in    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_top_ff <= '0;
         row_mid_ff <= (3*TW)'(1) << TW;
         row_bot_ff <= '0;
         width_ff   <= SW'(7);
         height_ff  <= SW'(7);
         mode_ff    <= 1'b1;
      end else begin
         row_top_ff <= row_top_in;
         row_mid_ff <= row_mid_in;
         row_bot_ff <= row_bot_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         mode_ff    <= mode_in;
      end
   end

   // Taps are split out per column; sizes are held between three and the maximum.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cfg.taps[0][j] = row_top_ff[TW*j +: TW];
         cfg.taps[1][j] = row_mid_ff[TW*j +: TW];
         cfg.taps[2][j] = row_bot_ff[TW*j +: TW];
      end
      if (width_ff < SW'(3)) begin
         cfg.width = SW'(3);
      end else if (width_ff > SW'(cif_pkg::MAX_WIDTH)) begin
         cfg.width = SW'(cif_pkg::MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff < SW'(3)) begin
         cfg.height = SW'(3);
      end else if (height_ff > SW'(cif_pkg::MAX_HEIGHT)) begin
         cfg.height = SW'(cif_pkg::MAX_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
      cfg.padded = mode_ff;
   end

endmodule

/* hdl/cif_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_front: position tracking, line stores and window
// Tracks the raster position, reads and updates the two line stores and
// shifts the 3x3 window, handing one job per pixel to the result stage.
// ----------------------------------------------------------------------------
module cif_front (
   input  logic                           clock,
   input  logic                           reset,
   input  cif_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cif_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                           req_frame_start,
   output logic                           job_valid,
   output cif_pkg::job_type               job,
   input  logic                           job_take
);

   localparam int RW = cif_pkg::ROW_W;
   localparam int CW = cif_pkg::COL_W;
   localparam int SW = cif_pkg::SIZE_W;

   logic [RW-1:0] pos_row_ff, pos_row_in;
   logic [CW-1:0] pos_col_ff, pos_col_in;

   logic                 a_valid_ff, a_valid_in;
   cif_pkg::pixel_type   a_pixel_ff;
   logic [RW-1:0]        a_row_ff;
   logic [CW-1:0]        a_col_ff;

   logic                 job_valid_ff, job_valid_in;
   cif_pkg::job_type     job_ff, job_in;

   logic                 accept;
   logic                 a_move;
   logic                 job_ready;
   logic [SW-1:0]        row_t;
   logic [SW-1:0]        col_t;
   logic [RW-1:0]        cur_row;
   logic [CW-1:0]        cur_col;
   cif_pkg::pixel_type   upper_rd;
   cif_pkg::pixel_type   lower_rd;

   assign job_ready = !job_valid_ff || job_take;
   assign a_move    = a_valid_ff && job_ready;
   assign req_ready = !a_valid_ff || a_move;
   assign accept    = req_valid && req_ready;

   // Position of the incoming pixel, allowing for a size that shrank mid-frame.
   always_comb begin
      col_t = req_frame_start ? '0 : SW'(pos_col_ff);
      row_t = req_frame_start ? '0 : SW'(pos_row_ff);
      if (col_t >= cfg.width) begin
         col_t = '0;
         row_t = row_t + SW'(1);
      end
      if (row_t >= cfg.height) begin
         row_t = '0;
      end
      cur_row = row_t[RW-1:0];
      cur_col = col_t[CW-1:0];

      pos_row_in = pos_row_ff;
      pos_col_in = pos_col_ff;
      if (accept) begin
         if (SW'(cur_col) + SW'(1) < cfg.width) begin
            pos_col_in = cur_col + CW'(1);
            pos_row_in = cur_row;
         end else begin
            pos_col_in = '0;
            pos_row_in = (SW'(cur_row) + SW'(1) < cfg.height) ? cur_row + RW'(1) : '0;
         end
      end
   end

   cif_ram #(
      .WIDTH (cif_pkg::PIXEL_W),
      .DEPTH (cif_pkg::MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data (lower_rd),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (upper_rd)
   );

   cif_ram #(
      .WIDTH (cif_pkg::PIXEL_W),
      .DEPTH (cif_pkg::MAX_WIDTH)
   ) u_lower (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data (a_pixel_ff),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (lower_rd)
   );

   always_comb begin
      a_valid_in = accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      job_valid_in = a_move ? 1'b1 : (job_take ? 1'b0 : job_valid_ff);
      job_in = job_ff;
      if (a_move) begin
         for (int t = 0; t < 3; t++) begin
            job_in.window[t][0] = job_ff.window[t][1];
            job_in.window[t][1] = job_ff.window[t][2];
         end
         job_in.window[0][2] = upper_rd;
         job_in.window[1][2] = lower_rd;
         job_in.window[2][2] = a_pixel_ff;
         job_in.row          = a_row_ff;
         job_in.col          = a_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_row_ff   <= '0;
         pos_col_ff   <= '0;
         a_valid_ff   <= 1'b0;
         job_valid_ff <= 1'b0;
         job_ff       <= '0;
      end else begin
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         a_valid_ff   <= a_valid_in;
         job_valid_ff <= job_valid_in;
         job_ff       <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pixel_ff <= req_pixel;
         a_row_ff   <= cur_row;
         a_col_ff   <= cur_col;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

/* hdl/cif_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_mac: result sequencing and multiply-accumulate
// Issues the results of each job one per cycle while the output side keeps
// up, forms nine products in a register stage and sums them into the output register.
// ----------------------------------------------------------------------------
module cif_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  cif_pkg::cfg_type                    cfg,
   input  logic                                job_valid,
   input  cif_pkg::job_type                    job,
   output logic                                job_take,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cif_pkg::VALUE_W-1:0]  rsp_value,
   output logic [cif_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [cif_pkg::COL_W-1:0]           rsp_out_col,
   output logic                                rsp_last,
   output logic                                rsp_frame_end
);

   localparam int RW = cif_pkg::ROW_W;
   localparam int CW = cif_pkg::COL_W;
   localparam int SW = cif_pkg::SIZE_W;
   localparam int PW = cif_pkg::PROD_W;
   localparam int VW = cif_pkg::VALUE_W;
   localparam int RN = cif_pkg::RESULT_N;

   logic [RN-1:0] done_ff, done_in;

   logic                 p_valid_ff, p_valid_in;
   logic signed [PW-1:0] p_prod_ff [3][3];
   logic [RW-1:0]        p_row_ff;
   logic [CW-1:0]        p_col_ff;
   logic                 p_last_ff;
   logic                 p_frame_end_ff;

   logic                 o_valid_ff, o_valid_in;
   logic signed [VW-1:0] o_value_ff;
   logic [RW-1:0]        o_row_ff;
   logic [CW-1:0]        o_col_ff;
   logic                 o_last_ff;
   logic                 o_frame_end_ff;

   logic          row_last, col_last;
   logic [RN-1:0] flags, pend;
   logic [1:0]    sel;
   logic          more;
   logic          p_move, p_free, emit;
   logic [SW-1:0] cr_t, cc_t;
   logic [2:0]    row_ok, col_ok;
   cif_pkg::pixel_type eff [3][3];
   logic signed [PW-1:0] prod [3][3];
   logic signed [VW-1:0] sum;

   assign row_last = SW'(job.row) == cfg.height - SW'(1);
   assign col_last = SW'(job.col) == cfg.width - SW'(1);

   // Results in issue order: centre one up-left, one up at the right edge,
   // on the bottom row one left, and the bottom-right corner.
   always_comb begin
      flags[0] = cfg.padded ? (job.row != '0 && job.col != '0)
                            : (job.row >= RW'(2) && job.col >= CW'(2));
      flags[1] = cfg.padded && job.row != '0 && col_last;
      flags[2] = cfg.padded && row_last && job.col != '0;
      flags[3] = cfg.padded && row_last && col_last;
      pend     = flags & ~done_ff;
      priority if (pend[0]) sel = 2'd0;
      else if (pend[1])     sel = 2'd1;
      else if (pend[2])     sel = 2'd2;
      else                  sel = 2'd3;
      more = (pend & ~(RN'(1) << sel)) != '0;
   end

   assign p_move   = p_valid_ff && (!o_valid_ff || rsp_ready);
   assign p_free   = !p_valid_ff || p_move;
   assign emit     = job_valid && pend != '0 && p_free;
   assign job_take = job_valid && (pend == '0 || (emit && !more));

   always_comb begin
      if (job_take) begin
         done_in = '0;
      end else if (emit) begin
         done_in = done_ff | (RN'(1) << sel);
      end else begin
         done_in = done_ff;
      end
   end

   // Centre of the selected result and which of its neighbours lie inside the image.
   always_comb begin
      cr_t = SW'(job.row) - SW'(1) + SW'(sel[1]);
      cc_t = SW'(job.col) - SW'(1) + SW'(sel[0]);
      row_ok[0] = cr_t != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = cr_t + SW'(1) < cfg.height;
      col_ok[0] = cc_t != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = cc_t + SW'(1) < cfg.width;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            eff[i][j] = '0;
            if (row_ok[i] && col_ok[j] && (i + int'(sel[1])) <= 2
                && (j + int'(sel[0])) <= 2) begin
               eff[i][j] = job.window[i + int'(sel[1])][j + int'(sel[0])];
            end
            prod[i][j] = PW'($signed(cfg.taps[i][j])) * $signed(PW'(eff[i][j]));
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum = sum + VW'(p_prod_ff[i][j]);
         end
      end
   end

   assign p_valid_in = emit ? 1'b1 : (p_move ? 1'b0 : p_valid_ff);
   assign o_valid_in = p_move ? 1'b1 : (rsp_ready ? 1'b0 : o_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff    <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         done_ff    <= done_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         p_prod_ff      <= prod;
         p_row_ff       <= cr_t[RW-1:0];
         p_col_ff       <= cc_t[CW-1:0];
         p_last_ff      <= !more;
         p_frame_end_ff <= !more && row_last && col_last;
      end
      if (p_move) begin
         o_value_ff     <= sum;
         o_row_ff       <= p_row_ff;
         o_col_ff       <= p_col_ff;
         o_last_ff      <= p_last_ff;
         o_frame_end_ff <= p_frame_end_ff;
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_value     = o_value_ff;
   assign rsp_out_row   = o_row_ff;
   assign rsp_out_col   = o_col_ff;
   assign rsp_last      = o_last_ff;
   assign rsp_frame_end = o_frame_end_ff;

endmodule

/* hdl/conv3x3_image_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_image_filter_unit: streaming 3x3 image filter
// Correlates a raster pixel stream with a programmable 3x3 kernel, with
// interior-only or zero-padded full-size output.
// ----------------------------------------------------------------------------
// The unit takes one 8-bit pixel per transaction in raster order and returns
// 28-bit signed correlation results with their row and column. A pixel that
// causes k results (up to four at the right edge and on the last row in
// padded mode) holds the input until they have issued, because results leave
// through the single multiply-accumulate path at one per clock while the
// result side keeps up. Over a frame there is one result per pixel at most,
// so the sustained rate is one pixel per clock when the result side keeps
// up. The pixel and its line store read are registered at acceptance,
// followed by the window register, the product register and the output
// register. The ready of the result side reaches the pixel input
// combinationally, so a result waiting to be taken stops new pixels once the
// registers behind it are full.
// Write configuration only while the unit is idle; sizes below three or above
// 64 are treated as three or 64.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_unit (
   input  logic   clock,
   input  logic   reset,
   cif_req_if.sink   req_chan,
   cif_rsp_if.source rsp_chan,
   cif_csr_if.sink   csr_chan
);

   cif_pkg::cfg_type cfg;
   cif_pkg::job_type job;
   logic             job_valid;
   logic             job_take;

   // Configuration registers; the clamped image size is computed here once.
   cif_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .cfg       (cfg)
   );

   // Raster position, both line stores and the 3x3 window.
   cif_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_pixel       (req_chan.pixel),
      .req_frame_start (req_chan.frame_start),
      .job_valid       (job_valid),
      .job             (job),
      .job_take        (job_take)
   );

   // Result issue, nine products and the summing output register.
   cif_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .job_valid     (job_valid),
      .job           (job),
      .job_take      (job_take),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_value     (rsp_chan.value),
      .rsp_out_row   (rsp_chan.out_row),
      .rsp_out_col   (rsp_chan.out_col),
      .rsp_last      (rsp_chan.last),
      .rsp_frame_end (rsp_chan.frame_end)
   );

endmodule

/* test/cif_tb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_tb_checker: result predictor and scoreboard for the 3x3 image filter
// Watches the pixel, result and register write channels, predicts every
// result from its own copy of the filter state and compares field by field.
// ----------------------------------------------------------------------------
module cif_tb_checker (
   input  logic  clock,
   input  logic  reset,
   cif_req_if    req_chan,
   cif_rsp_if    rsp_chan,
   cif_csr_if    csr_chan,
   output int    error_count,
   output int    pending_count
);

   typedef struct packed {
      logic signed [cif_pkg::VALUE_W-1:0] value;
      logic [cif_pkg::ROW_W-1:0]          out_row;
      logic [cif_pkg::COL_W-1:0]          out_col;
      logic                               last;
      logic                               frame_end;
   } result_type;

   result_type expected_results[$];

   logic [cif_pkg::CSR_DATA_W-1:0] kernel_rows[3];
   logic [cif_pkg::SIZE_W-1:0]     width_reg, height_reg;
   logic                           padded_reg;
   cif_pkg::pixel_type             upper_line[cif_pkg::MAX_WIDTH];
   cif_pkg::pixel_type             lower_line[cif_pkg::MAX_WIDTH];
   cif_pkg::pixel_type             win[3][3];
   int                             row_pos, col_pos;

   assign pending_count = expected_results.size();

   function automatic int clamp_size(logic [cif_pkg::SIZE_W-1:0] v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic logic signed [cif_pkg::VALUE_W-1:0] correlate(int cr, int cc,
                                                                    int r, int c,
                                                                    int w, int h);
      int sum, ir, ic, t, k;
      logic signed [cif_pkg::TAP_W-1:0] tap;
      sum = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            ir = cr + dr;
            ic = cc + dc;
            t  = ir - (r - 2);
            k  = ic - (c - 2);
            if (ir >= 0 && ir < h && ic >= 0 && ic < w && t >= 0 && t <= 2
                && k >= 0 && k <= 2) begin
               tap = kernel_rows[dr + 1][cif_pkg::TAP_W * (dc + 1) +: cif_pkg::TAP_W];
               sum += int'(tap) * int'(win[t][k]);
            end
         end
      end
      return sum[cif_pkg::VALUE_W-1:0];
   endfunction

   task automatic predict_pixel(cif_pkg::pixel_type px, logic fs);
      int w, h, r, c, n;
      int pos[4][2];
      logic frame_last;
      result_type res;
      w = clamp_size(width_reg, cif_pkg::MAX_WIDTH);
      h = clamp_size(height_reg, cif_pkg::MAX_HEIGHT);
      n = 0;
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = lower_line[c];
      win[2][2] = px;
      upper_line[c] = lower_line[c];
      lower_line[c] = px;
      if (!padded_reg) begin
         if (r >= 2 && c >= 2) begin
            pos[n] = '{r - 1, c - 1}; n++;
         end
      end else begin
         if (r >= 1) begin
            if (c >= 1) begin
               pos[n] = '{r - 1, c - 1}; n++;
            end
            if (c == w - 1) begin
               pos[n] = '{r - 1, w - 1}; n++;
            end
         end
         if (r == h - 1) begin
            if (c >= 1) begin
               pos[n] = '{r, c - 1}; n++;
            end
            if (c == w - 1) begin
               pos[n] = '{r, w - 1}; n++;
            end
         end
      end
      frame_last = (r == h - 1) && (c == w - 1);
      for (int i = 0; i < n; i++) begin
         res.value     = correlate(pos[i][0], pos[i][1], r, c, w, h);
         res.out_row   = pos[i][0][cif_pkg::ROW_W-1:0];
         res.out_col   = pos[i][1][cif_pkg::COL_W-1:0];
         res.last      = (i == n - 1);
         res.frame_end = (i == n - 1) && frame_last;
         expected_results.push_back(res);
      end
      col_pos = c + 1;
      row_pos = r;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         kernel_rows[0] = '0;
         kernel_rows[1] = 48'h10000;
         kernel_rows[2] = '0;
         width_reg      = 7;
         height_reg     = 7;
         padded_reg     = 1'b1;
         for (int i = 0; i < 3; i++) win[i] = '{default: '0};
         row_pos        = 0;
         col_pos        = 0;
         error_count    = 0;
         expected_results.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               cif_pkg::CSR_KERNEL_TOP:    kernel_rows[0] = csr_chan.data;
               cif_pkg::CSR_KERNEL_MID:    kernel_rows[1] = csr_chan.data;
               cif_pkg::CSR_KERNEL_BOTTOM: kernel_rows[2] = csr_chan.data;
               cif_pkg::CSR_IMAGE_WIDTH:   width_reg  = csr_chan.data[cif_pkg::SIZE_W-1:0];
               cif_pkg::CSR_IMAGE_HEIGHT:  height_reg = csr_chan.data[cif_pkg::SIZE_W-1:0];
               cif_pkg::CSR_BORDER_MODE:   padded_reg = csr_chan.data[0];
               default: ;
            endcase
         end
         // Results are checked before this edge's pixel is predicted, since
         // a pixel's results appear only after it has passed the unit's registers.
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.value, rsp_chan.out_row, rsp_chan.out_col,
                    rsp_chan.last, rsp_chan.frame_end};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %p", $realtime, got);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            predict_pixel(req_chan.pixel, req_chan.frame_start);
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the 3x3 image filter unit
// Programs kernels, sizes and border modes, streams whole frames of pixels
// with random gaps and receiver stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic [cif_pkg::CSR_DATA_W-1:0] csr_data_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count, pending_count;
   int   idle_cycles = 0;
   int   rsp_stall = 0;
   bit   hold_off = 1'b0;   // forces a long stall of the receiver

   cif_req_if req_chan();
   cif_rsp_if rsp_chan();
   cif_csr_if csr_chan();

   always #4 clock = ~clock;

   conv3x3_image_filter_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   cif_tb_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.pixel       = '0;
      req_chan.frame_start = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = cif_pkg::CSR_KERNEL_TOP;
      csr_chan.data        = '0;
   end

   // Mostly short gaps, now and then a long one, with stretches of none.
   function automatic int gap_length(int stretch);
      int roll;
      roll = $urandom_range(99);
      if (stretch < 30 || roll < 40) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Receiver: stalls of random length, plus the long hold-off when requested.
   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall      <= rsp_stall - 1;
         end else begin
            stall = gap_length($urandom_range(99));
            rsp_chan.ready <= (stall == 0);
            rsp_stall      <= (stall > 0) ? stall - 1 : 0;
         end
      end
   end

   // Watchdog: counts clocks in which no transaction of any channel happens and no hold-off is active.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready) || hold_off) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL conv3x3_image_filter_unit");
            $finish;
         end
      end
   end

   // Leaves valid high so that writes follow each other; the caller drops it.
   task automatic write_register(logic [cif_pkg::CSR_ADDR_W-1:0] index, csr_data_type data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Sends one pixel transaction after an optional gap.
   task automatic send_pixel(cif_pkg::pixel_type px, logic fs, int stretch);
      int gap;
      gap = gap_length(stretch);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pixel       <= px;
      req_chan.frame_start <= fs;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Waits until every predicted result has been taken, then lets the
   // pipeline drain its latency before the registers are touched.
   task automatic wait_idle();
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(csr_data_type k0, csr_data_type k1, csr_data_type k2,
                            int w, int h, logic padded);
      write_register(cif_pkg::CSR_KERNEL_TOP, k0);
      write_register(cif_pkg::CSR_KERNEL_MID, k1);
      write_register(cif_pkg::CSR_KERNEL_BOTTOM, k2);
      write_register(cif_pkg::CSR_IMAGE_WIDTH, csr_data_type'(w));
      write_register(cif_pkg::CSR_IMAGE_HEIGHT, csr_data_type'(h));
      write_register(cif_pkg::CSR_BORDER_MODE, csr_data_type'(padded));
      csr_chan.valid <= 1'b0;
   endtask

   function automatic csr_data_type random_row();
      return csr_data_type'({$urandom, $urandom});
   endfunction

   // Streams whole frames; frame_start is always set on the first pixel of the first
   // frame and at random on the first pixel of later ones, so frames also follow each other by wrapping.
   task automatic send_frames(int frames, int w, int h, int mode);
      cif_pkg::pixel_type px;
      int stretch;
      stretch = $urandom_range(99);
      for (int f = 0; f < frames; f++) begin
         for (int i = 0; i < w * h; i++) begin
            case (mode)
               0: px = cif_pkg::pixel_type'($urandom);
               1: px = (i % 2) ? 8'hFF : 8'h00;
               default: px = $urandom_range(1) ? 8'hFF : cif_pkg::pixel_type'($urandom);
            endcase
            if (i % 17 == 0) stretch = $urandom_range(99);
            send_pixel(px, (i == 0) && (f == 0 || $urandom_range(1)), stretch);
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      int w, h;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset kernel is identity, 7x7 padded frame of extremes,
      // sent without any register write first.
      send_frames(1, 7, 7, 1);
      wait_idle();

      // Most negative and most positive taps, smallest frame, both modes.
      configure({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 3, 3, 1'b1);
      send_frames(1, 3, 3, 2);
      wait_idle();
      configure({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 3, 3, 1'b0);
      send_frames(1, 3, 3, 2);
      wait_idle();

      // Out-of-range sizes are clamped; width 0 acts as 3, 127 as 64.
      configure(random_row(), random_row(), random_row(), 0, 127, 1'b0);
      send_frames(1, 3, 4, 0);   // partial frame: only first rows, all written
      wait_idle();
      configure(random_row(), random_row(), random_row(), 64, 3, 1'b1);
      send_frames(1, 64, 3, 0);
      wait_idle();

      // Long hold-off: the receiver stops while pixels keep coming.
      configure(random_row(), random_row(), random_row(), 5, 4, 1'b1);
      hold_off = 1'b1;
      fork
         send_frames(1, 5, 4, 0);
         begin
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      wait_idle();

      // Random: small frames of random sizes, kernels and modes.
      for (int phase = 0; phase < 4; phase++) begin
         w = $urandom_range(6, 3);
         h = $urandom_range(6, 3);
         configure(random_row(), random_row(), random_row(), w, h, 1'($urandom_range(1)));
         send_frames($urandom_range(2, 1), w, h, $urandom_range(2));
         wait_idle();
      end

      if (error_count == 0) begin
         $display("PASS conv3x3_image_filter_unit");
      end else begin
         $display("FAIL conv3x3_image_filter_unit");
      end
      $finish;
   end

endmodule
